/* rtl/mau_pkg.sv */
`default_nettype none

package mau_pkg;

   // width of the operation code on the request channel
   localparam int REQ_TYPE_BITS = 3;

   // operation codes carried in req_type
   localparam logic [REQ_TYPE_BITS-1:0] REQ_ADD = 3'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SUB = 3'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_MUL = 3'd2;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_POW = 3'd3;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_DIV = 3'd4;

   // modulus after reset, before truncation to the configured width
   localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

   // operations of the serial arithmetic unit
   typedef enum logic [1:0] {
      UOP_ADD = 2'd0,
      UOP_SUB = 2'd1,
      UOP_MUL = 2'd2,
      UOP_RED = 2'd3
   } mau_uop_type;

   typedef struct packed {
      logic        start;
      mau_uop_type op;
   } mau_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mau_sts_type;

endpackage

`default_nettype wire

/* rtl/mau_req_if.sv */
`default_nettype none

interface mau_req_if
   import mau_pkg::*;
#(
   parameter int OPERAND_BITS = 32
) ();

   logic                     valid;
   logic                     ready;
   logic [REQ_TYPE_BITS-1:0] req_type;
   logic [OPERAND_BITS-1:0]  operand_a;
   logic [OPERAND_BITS-1:0]  operand_b;

   modport source (output valid, req_type, operand_a, operand_b, input ready);
   modport sink   (input valid, req_type, operand_a, operand_b, output ready);

endinterface

`default_nettype wire

/* rtl/mau_rsp_if.sv */
`default_nettype none

interface mau_rsp_if #(
   parameter int MODULUS_BITS = 31
) ();

   logic                    valid;
   logic                    ready;
   logic [MODULUS_BITS-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);

endinterface

`default_nettype wire

/* rtl/modular_arithmetic_unit_top.sv */
`default_nettype none

// Modular arithmetic unit: add, subtract, multiply, power and Fermat divide
// modulo a configured modulus.
// req_chan: valid/ready transaction with req_type, operand_a, operand_b.
// rsp_chan: valid/ready transaction with result, one per request.
// csr_wr_en/csr_wr_data: write the modulus; only while no request is in flight.
// One request is worked on at a time; req_chan.ready is high only when idle.
// Both operands are first reduced bit-serially.
// Every modular product runs through a serial unit, one double and one conditional add per modulus bit.
// Power runs one round per bit of the exponent; divide runs as a power with
// exponent modulus-2, then multiplies that result by operand a.
// The next request can be accepted in the cycle after a result is loaded.
// The two serial units run the multiply and the square of a power round in
// parallel; the round loop sets the rate.
// A finished result sits in the output register until taken; a following
// request can be accepted meanwhile, and its result waits if rsp is stalled.
// Reset returns to idle, drops any pending result and loads the modulus
// 1000000007 (truncated to MODULUS_BITS).
module modular_arithmetic_unit_top
   import mau_pkg::*;
#(
   parameter int OPERAND_BITS = 32,
   parameter int MODULUS_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   mau_req_if.sink                      req_chan,
   mau_rsp_if.source                    rsp_chan,
   input  wire logic                    csr_wr_en,
   input  wire logic [MODULUS_BITS-1:0] csr_wr_data
);

   localparam int SHW = (OPERAND_BITS > MODULUS_BITS) ? OPERAND_BITS : MODULUS_BITS;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_RED      = 6'b000010,
      ST_DISPATCH = 6'b000100,
      ST_POW      = 6'b001000,
      ST_FINAL    = 6'b010000,
      ST_OUT      = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [MODULUS_BITS-1:0]  modulus_ff, modulus_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MODULUS_BITS-1:0]  rsp_result_ff, rsp_result_in;

   logic [REQ_TYPE_BITS-1:0] op_ff, op_in;
   logic [OPERAND_BITS-1:0]  b_raw_ff, b_raw_in;
   logic [MODULUS_BITS-1:0]  a_ff, a_in;
   logic [MODULUS_BITS-1:0]  b_ff, b_in;
   logic [MODULUS_BITS-1:0]  acc_ff, acc_in;
   logic [MODULUS_BITS-1:0]  base_ff, base_in;
   logic [SHW-1:0]           exp_ff, exp_in;
   logic [MODULUS_BITS-1:0]  res_ff, res_in;

   mau_cmd_type              u0_cmd, u1_cmd;
   mau_sts_type              u0_sts, u1_sts;
   logic [MODULUS_BITS-1:0]  u0_x, u1_x, u0_result, u1_result;
   logic [SHW-1:0]           u0_y, u1_y;

   logic                     accept;
   logic                     rsp_load;
   logic [MODULUS_BITS-1:0]  one_mod;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   // 1 mod m: zero when the modulus is one
   assign one_mod  = (modulus_ff == MODULUS_BITS'(1)) ? '0 : MODULUS_BITS'(1);

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;

   // sequencer: reduce, dispatch, run power rounds, finish, hand off
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      b_raw_in = b_raw_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      exp_in   = exp_ff;
      res_in   = res_ff;
      u0_cmd   = '{start: 1'b0, op: UOP_RED};
      u1_cmd   = '{start: 1'b0, op: UOP_RED};
      u0_x     = a_ff;
      u0_y     = SHW'(b_ff);
      u1_x     = base_ff;
      u1_y     = SHW'(base_ff);
      unique case (state_ff)
         ST_IDLE: begin
            u0_x = '0;
            u0_y = SHW'(req_chan.operand_a);
            u1_x = '0;
            u1_y = SHW'(req_chan.operand_b);
            if (accept) begin
               // start reducing both operands at once
               op_in    = req_chan.req_type;
               b_raw_in = req_chan.operand_b;
               u0_cmd   = '{start: 1'b1, op: UOP_RED};
               u1_cmd   = '{start: 1'b1, op: UOP_RED};
               state_in = ST_RED;
            end
         end
         ST_RED: begin
            if (u0_sts.done) begin
               a_in     = u0_result;
               b_in     = u1_result;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_in = '0;
            if (modulus_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               unique case (op_ff)
                  REQ_ADD: begin
                     u0_cmd   = '{start: 1'b1, op: UOP_ADD};
                     state_in = ST_FINAL;
                  end
                  REQ_SUB: begin
                     u0_cmd   = '{start: 1'b1, op: UOP_SUB};
                     state_in = ST_FINAL;
                  end
                  REQ_MUL: begin
                     u0_cmd   = '{start: 1'b1, op: UOP_MUL};
                     state_in = ST_FINAL;
                  end
                  REQ_POW: begin
                     acc_in   = one_mod;
                     base_in  = a_ff;
                     exp_in   = SHW'(b_raw_ff);
                     state_in = ST_POW;
                  end
                  REQ_DIV: begin
                     // zero divisor or a modulus below two gives zero
                     if (b_ff == '0 || modulus_ff < MODULUS_BITS'(2)) begin
                        state_in = ST_OUT;
                     end else begin
                        acc_in   = one_mod;
                        base_in  = b_ff;
                        exp_in   = SHW'(modulus_ff - MODULUS_BITS'(2));
                        state_in = ST_POW;
                     end
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_POW: begin
            u0_x = acc_ff;
            u0_y = SHW'(base_ff);
            if (u0_sts.done) begin
               // take the product only for a set exponent bit; always square
               if (exp_ff[0]) begin
                  acc_in = u0_result;
               end
               base_in = u1_result;
               exp_in  = exp_ff >> 1;
            end else if (!u0_sts.busy) begin
               if (exp_ff == '0) begin
                  if (op_ff == REQ_DIV) begin
                     u0_x     = a_ff;
                     u0_y     = SHW'(acc_ff);
                     u0_cmd   = '{start: 1'b1, op: UOP_MUL};
                     state_in = ST_FINAL;
                  end else begin
                     res_in   = acc_ff;
                     state_in = ST_OUT;
                  end
               end else begin
                  u0_cmd = '{start: 1'b1, op: UOP_MUL};
                  u1_cmd = '{start: 1'b1, op: UOP_MUL};
               end
            end
         end
         ST_FINAL: begin
            if (u0_sts.done) begin
               res_in   = u0_result;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: hold until taken, load when free or being drained
   always_comb begin
      rsp_result_in = rsp_result_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = res_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign modulus_in = csr_wr_en ? csr_wr_data : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_BITS'(MODULUS_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      b_raw_ff      <= b_raw_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      acc_ff        <= acc_in;
      base_ff       <= base_in;
      exp_ff        <= exp_in;
      res_ff        <= res_in;
      rsp_result_ff <= rsp_result_in;
   end

   // unit 0: reduce operand a, run the accumulator product, finish
   mau_serial_alu #(
      .OPERAND_BITS (OPERAND_BITS),
      .MODULUS_BITS (MODULUS_BITS)
   ) u_alu0 (
      .clock   (clock),
      .reset   (reset),
      .cmd     (u0_cmd),
      .x       (u0_x),
      .y       (u0_y),
      .modulus (modulus_ff),
      .sts     (u0_sts),
      .result  (u0_result)
   );

   // unit 1: reduce operand b, square the base
   mau_serial_alu #(
      .OPERAND_BITS (OPERAND_BITS),
      .MODULUS_BITS (MODULUS_BITS)
   ) u_alu1 (
      .clock   (clock),
      .reset   (reset),
      .cmd     (u1_cmd),
      .x       (u1_x),
      .y       (u1_y),
      .modulus (modulus_ff),
      .sts     (u1_sts),
      .result  (u1_result)
   );

   // an accepted transaction always begins with operand reduction
   a_accept_to_red: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_RED)
      else $error("accepted transaction did not enter reduction");

   // while reducing and running power rounds both units run in lock step
   a_units_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RED || state_ff == ST_POW) |-> u0_sts.done == u1_sts.done)
      else $error("serial units out of step");

   // never start a unit that is still working
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      (u0_cmd.start |-> !u0_sts.busy) and (u1_cmd.start |-> !u1_sts.busy))
      else $error("serial unit started while busy");

   // a result with a free output register is presented next cycle
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && !rsp_valid_ff |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not moved to output register");

endmodule

`default_nettype wire

/* rtl/mau_serial_alu.sv */
`default_nettype none

module mau_serial_alu
   import mau_pkg::*;
#(
   parameter int OPERAND_BITS = 32,
   parameter int MODULUS_BITS = 31
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mau_cmd_type              cmd,
   input  wire logic [MODULUS_BITS-1:0]  x,
   input  wire logic [((OPERAND_BITS > MODULUS_BITS) ? OPERAND_BITS : MODULUS_BITS)-1:0] y,
   input  wire logic [MODULUS_BITS-1:0]  modulus,
   output mau_sts_type                   sts,
   output logic [MODULUS_BITS-1:0]       result
);

   localparam int SHW    = (OPERAND_BITS > MODULUS_BITS) ? OPERAND_BITS : MODULUS_BITS;
   localparam int CNTW   = $clog2(SHW + 1);
   localparam int SH_MUL = SHW - MODULUS_BITS;
   localparam int SH_RED = SHW - OPERAND_BITS;

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_ONE  = 4'b0010,
      U_DBL  = 4'b0100,
      U_ADD  = 4'b1000
   } u_state_type;

   u_state_type             state_ff, state_in;
   mau_uop_type             op_ff, op_in;
   logic                    done_ff, done_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic [MODULUS_BITS-1:0] acc_ff, acc_in;
   logic [MODULUS_BITS-1:0] x_ff, x_in;
   logic [SHW-1:0]          y_ff, y_in;

   // one modular add or subtract per cycle; operands are below the modulus
   logic [MODULUS_BITS-1:0] p, q;
   logic                    cin, subtract;
   logic [MODULUS_BITS:0]   sum, diff, wrap;
   logic [MODULUS_BITS+1:0] over;
   logic [MODULUS_BITS-1:0] madd;

   assign sum  = {1'b0, p} + {1'b0, q} + {{MODULUS_BITS{1'b0}}, cin};
   assign over = {1'b0, sum} - {2'b00, modulus};
   assign diff = {1'b0, p} - {1'b0, q};
   assign wrap = diff + {1'b0, modulus};

   always_comb begin
      if (subtract) begin
         madd = diff[MODULUS_BITS] ? wrap[MODULUS_BITS-1:0] : diff[MODULUS_BITS-1:0];
      end else begin
         madd = over[MODULUS_BITS+1] ? sum[MODULUS_BITS-1:0] : over[MODULUS_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      p        = acc_ff;
      q        = acc_ff;
      cin      = 1'b0;
      subtract = 1'b0;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               op_in = cmd.op;
               x_in  = x;
               unique case (cmd.op)
                  UOP_ADD, UOP_SUB: begin
                     acc_in   = y[MODULUS_BITS-1:0];
                     y_in     = y;
                     cnt_in   = CNTW'(1);
                     state_in = U_ONE;
                  end
                  UOP_MUL: begin
                     acc_in   = '0;
                     y_in     = y << SH_MUL;
                     cnt_in   = CNTW'(MODULUS_BITS);
                     state_in = U_DBL;
                  end
                  default: begin
                     acc_in   = '0;
                     y_in     = y << SH_RED;
                     cnt_in   = CNTW'(OPERAND_BITS);
                     state_in = U_DBL;
                  end
               endcase
            end
         end
         U_ONE: begin
            p        = x_ff;
            q        = acc_ff;
            subtract = (op_ff == UOP_SUB);
            acc_in   = madd;
            done_in  = 1'b1;
            state_in = U_IDLE;
         end
         U_DBL: begin
            // double; a reduction also shifts the next operand bit in
            cin    = (op_ff == UOP_RED) ? y_ff[SHW-1] : 1'b0;
            acc_in = madd;
            if (op_ff == UOP_RED) begin
               y_in   = y_ff << 1;
               cnt_in = cnt_ff - CNTW'(1);
               if (cnt_ff == CNTW'(1)) begin
                  done_in  = 1'b1;
                  state_in = U_IDLE;
               end
            end else begin
               state_in = U_ADD;
            end
         end
         U_ADD: begin
            // add the multiplicand when the multiplier bit is set
            q      = y_ff[SHW-1] ? x_ff : '0;
            acc_in = madd;
            y_in   = y_ff << 1;
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else begin
               state_in = U_DBL;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign sts.busy = (state_ff != U_IDLE);
   assign sts.done = done_ff;
   assign result   = acc_ff;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

// Testbench for modular_arithmetic_unit_top.
// Each request transaction is mirrored by an in-bench residue predictor. The
// prediction is queued on acceptance, and the response sink compares every
// response transaction against the oldest queued residue.
module tb;
   import mau_pkg::*;

   localparam int OPERAND_BITS = 32;
   localparam int MODULUS_BITS = 31;

   // clock half periods: 12 time units per cycle
   localparam int CLK_HIGH = 6;
   localparam int CLK_LOW  = 6;

   // settle before a modulus write; every request yields a response, so keep it short
   localparam int CSR_SETTLE_CYCLES = 8;
   // settle at the end: about one full power round loop
   localparam int END_SETTLE_CYCLES = 2200;
   // long response back-pressure that fills the output register and the engine
   localparam int RSP_HOLD_CYCLES   = 400;
   // worst case: ~300 full-length transactions plus stalls, taken about six times over
   localparam longint RUN_LIMIT     = 48_000_000;

   // operation codes the package leaves undefined; the block answers them with 0
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RSVD_LO  = 3'd5;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RSVD_MID = 3'd6;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RSVD_HI  = 3'd7;

   typedef logic [REQ_TYPE_BITS-1:0] opcode_t;
   typedef logic [OPERAND_BITS-1:0]  operand_t;
   typedef logic [MODULUS_BITS-1:0]  residue_t;

   // one predicted response, with its request kept for mismatch reports
   typedef struct {
      opcode_t  op;
      operand_t a;
      operand_t b;
      residue_t modulus;
      residue_t residue;
   } residue_entry_t;

   logic     clock;
   logic     reset;
   logic     csr_wr_en;
   residue_t csr_wr_data;

   mau_req_if #(.OPERAND_BITS(OPERAND_BITS)) req_chan ();
   mau_rsp_if #(.MODULUS_BITS(MODULUS_BITS)) rsp_chan ();

   modular_arithmetic_unit_top #(
      .OPERAND_BITS(OPERAND_BITS),
      .MODULUS_BITS(MODULUS_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // bench copy of the modulus register
   residue_t       modulus_shadow;
   // predicted residues, oldest first
   residue_entry_t pending_residues [$];

   int error_count      = 0;
   int residues_checked = 0;
   int modulus_writes   = 0;
   int op_count [0:7];
   int longest_req_wait = 0;

   // idle percentages, set per test phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // bump to ask the response sink for one long hold-off
   int hold_order    = 0;

   initial clock = 1'b0;

   always begin
      #CLK_HIGH clock = 1'b1;
      #CLK_LOW  clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Right-to-left square-and-multiply; operands stay below 2^31, so
   // every product fits in 64 bits.
   function automatic longint unsigned power_residue(longint unsigned base,
                                                      longint unsigned expo,
                                                      longint unsigned m);
      longint unsigned acc;
      acc = 64'd1 % m;
      while (expo != 0) begin
         if ((expo & 64'd1) != 0)
            acc = (acc * base) % m;
         base = (base * base) % m;
         expo = expo >> 1;
      end
      return acc;
   endfunction

   function automatic residue_t predict_residue(opcode_t op, operand_t a_raw,
                                                operand_t b_raw, residue_t m_cfg);
      longint unsigned m;
      longint unsigned a;
      longint unsigned b;
      longint unsigned r;
      m = m_cfg;
      r = 0;
      // a zero modulus has no reduction: every operation answers 0
      if (m != 0) begin
         a = a_raw % m;
         b = b_raw % m;
         case (op)
            REQ_ADD: begin
               r = a + b;
               if (r >= m)
                  r = r - m;
            end
            REQ_SUB: r = (a + m - b) % m;
            REQ_MUL: r = (a * b) % m;
            // exponent is used as given, not reduced
            REQ_POW: r = power_residue(a, b_raw, m);
            // Fermat inverse; a divisor that reduces to zero gives 0
            REQ_DIV: begin
               if (b == 0 || m < 2)
                  r = 0;
               else
                  r = (a * power_residue(b, m - 2, m)) % m;
            end
            default: r = 0;
         endcase
      end
      return residue_t'(r);
   endfunction

   // ------------------------------------------------------------------
   // Request source
   // ------------------------------------------------------------------

   // Offer one request and hold it until accepted. Leave valid high after
   // the transaction so back-to-back requests never drop it within a step.
   task automatic send_request(input opcode_t op, input operand_t a, input operand_t b);
      residue_entry_t entry;
      int             waited;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= op;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (!req_chan.ready);
      if (waited > longest_req_wait)
         longest_req_wait = waited;
      entry.op      = op;
      entry.a       = a;
      entry.b       = b;
      entry.modulus = modulus_shadow;
      entry.residue = predict_residue(op, a, b, modulus_shadow);
      pending_residues.insert(pending_residues.size(), entry);
      op_count[op]++;
   endtask

   // Drop valid, wait until every predicted residue has come back, then settle.
   task automatic wait_for_idle(input int settle_cycles);
      req_chan.valid <= 1'b0;
      while (pending_residues.size() != 0)
         @(posedge clock);
      repeat (settle_cycles) @(posedge clock);
   endtask

   // Write the modulus only with the block idle.
   task automatic write_modulus(input residue_t value);
      wait_for_idle(CSR_SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      modulus_shadow  = value;
      modulus_writes++;
   endtask

   // Operand mix: extremes, small values, values near multiples of m and random values.
   function automatic operand_t pick_operand(residue_t m);
      case ($urandom_range(0, 5))
         0:       return '1;
         1:       return operand_t'($urandom_range(0, 16));
         2:       return operand_t'(m) * $urandom_range(0, 2) + $urandom_range(0, 2);
         3:       return operand_t'(m) - 1;
         default: return operand_t'($urandom());
      endcase
   endfunction

   function automatic opcode_t pick_opcode();
      if ($urandom_range(0, 19) == 0)
         return opcode_t'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
      return opcode_t'($urandom_range(REQ_ADD, REQ_DIV));
   endfunction

   // ------------------------------------------------------------------
   // Response sink and checker
   // ------------------------------------------------------------------

   initial begin : rsp_sink
      residue_entry_t entry;
      int             hold_left;
      int             hold_taken;
      hold_left  = 0;
      hold_taken = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         // check the transaction seen at this edge
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_residues.size() == 0) begin
               $display("%0t: response %0d with no request outstanding",
                        $time, rsp_chan.result);
               error_count++;
            end else begin
               entry = pending_residues.pop_front();
               residues_checked++;
               if (rsp_chan.result !== entry.residue) begin
                  $display("%0t: op %0d a %0d b %0d mod %0d: expected %0d actual %0d",
                           $time, entry.op, entry.a, entry.b, entry.modulus,
                           entry.residue, rsp_chan.result);
                  error_count++;
               end
            end
         end
         // drive ready for the next edge
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_taken != hold_order) begin
            hold_taken      = hold_order;
            hold_left       = RSP_HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every operation at the reset modulus, with operand extremes, wrap on
   // subtract, zero exponent, zero divisor and undefined opcodes.
   task automatic test_operations_at_reset_modulus();
      send_request(REQ_ADD, '1, '1);
      send_request(REQ_ADD, '0, '0);
      send_request(REQ_SUB, 32'd0, 32'd1);
      send_request(REQ_SUB, 32'd5, 32'd1000000012);
      send_request(REQ_MUL, '1, 32'hFFFF_FFFE);
      send_request(REQ_POW, 32'd2, 32'd0);
      send_request(REQ_POW, 32'd0, 32'd0);
      send_request(REQ_POW, '1, '1);
      send_request(REQ_POW, 32'd3, 32'd1000000006);
      send_request(REQ_DIV, 32'd10, 32'd0);
      send_request(REQ_DIV, 32'd10, 32'd1000000007);
      send_request(REQ_DIV, '1, 32'd7);
      send_request(REQ_RSVD_LO, '1, '1);
      send_request(REQ_RSVD_MID, 32'd12345, 32'd678);
      send_request(REQ_RSVD_HI, '1, 32'd1);
   endtask

   // Moduli at and below the usable range: zero, one and two.
   task automatic test_degenerate_moduli();
      write_modulus('0);
      send_request(REQ_ADD, '1, 32'd3);
      send_request(REQ_SUB, 32'd1, 32'd2);
      send_request(REQ_MUL, '1, '1);
      send_request(REQ_POW, 32'd7, 32'd0);
      send_request(REQ_DIV, 32'd9, 32'd4);
      write_modulus(residue_t'(1));
      send_request(REQ_POW, 32'd5, 32'd0);
      send_request(REQ_DIV, 32'd3, 32'd4);
      send_request(REQ_ADD, '1, '1);
      write_modulus(residue_t'(2));
      send_request(REQ_POW, '1, '1);
      send_request(REQ_DIV, 32'd1, 32'd1);
   endtask

   // Hold the response side for a long stretch while requests keep coming:
   // the output register and the engine fill up and req ready must drop.
   task automatic test_output_backpressure();
      write_modulus(residue_t'(1000003));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_order++;
      repeat (10)
         send_request(opcode_t'($urandom_range(REQ_ADD, REQ_MUL)),
                      pick_operand(modulus_shadow), pick_operand(modulus_shadow));
      wait_for_idle(CSR_SETTLE_CYCLES);
   endtask

   // One random phase at a given modulus and idling pattern.
   task automatic run_random_phase(input residue_t modulus_value, input int send_pct,
                                   input int recv_pct, input int count);
      opcode_t  op;
      operand_t a;
      operand_t b;
      write_modulus(modulus_value);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) begin
         op = pick_opcode();
         a  = pick_operand(modulus_value);
         b  = pick_operand(modulus_value);
         // keep most exponents short; full-width ones run a full power round loop
         if (op == REQ_POW && $urandom_range(0, 2) != 0)
            b = operand_t'($urandom_range(0, 40));
         send_request(op, a, b);
      end
   endtask

   // Busy sender / sparse receiver, then the reverse, then no idling.
   task automatic test_random_traffic();
      run_random_phase(residue_t'(2147483647), 10, 52, 60);
      run_random_phase(residue_t'($urandom_range(2, 32'h7FFF_FFFF)), 10, 52, 30);
      run_random_phase(residue_t'(65521), 52, 10, 60);
      run_random_phase(residue_t'(3), 52, 10, 25);
      run_random_phase(residue_t'(1000000007), 0, 0, 60);
      run_random_phase(residue_t'(1000000), 0, 0, 25);
   endtask

   initial begin : stimulus
      foreach (op_count[i])
         op_count[i] = 0;
      // drive every input to a known value from time zero
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_ADD;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;
      modulus_shadow     = residue_t'(MODULUS_RESET);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_operations_at_reset_modulus();
      test_degenerate_moduli();
      test_output_backpressure();
      test_random_traffic();

      // let the last response arrive, then give the block time to misbehave
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_for_idle(END_SETTLE_CYCLES);

      $display("Checked %0d responses: add %0d, sub %0d, mul %0d, pow %0d, div %0d, other %0d",
               residues_checked, op_count[REQ_ADD], op_count[REQ_SUB], op_count[REQ_MUL],
               op_count[REQ_POW], op_count[REQ_DIV],
               op_count[REQ_RSVD_LO] + op_count[REQ_RSVD_MID] + op_count[REQ_RSVD_HI]);
      $display("%0d modulus writes from 0 to 2^31-1; longest request stall %0d cycles",
               modulus_writes, longest_req_wait);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog: a hung handshake ends the run here
   initial begin : watchdog
      #RUN_LIMIT;
      $display("%0t: run limit reached with %0d responses outstanding",
               $time, pending_residues.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
